// ----- hw/rtl/u2u_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u_pkg
// Shared types and constants of the UCS-2 to UTF-8 encoder.
// ----------------------------------------------------------------------------
package u2u_pkg;

    // result status codes
    typedef enum logic [1:0] {
        ST_BYTE    = 2'd0,
        ST_TERM    = 2'd1,
        ST_SURR    = 2'd2,
        ST_NOSPACE = 2'd3
    } t_status;

    // configuration register indexes
    localparam logic [1:0] CFG_IGNORE_ERRORS   = 2'd0;
    localparam logic [1:0] CFG_SKIP_BOM        = 2'd1;
    localparam logic [1:0] CFG_BUFFER_CAPACITY = 2'd2;

    localparam logic [15:0] CAPACITY_RESET = 16'hffff;

    // code unit classification
    localparam logic [15:0] SURR_LO      = 16'hd800;
    localparam logic [15:0] SURR_HI      = 16'hdfff;
    localparam logic [15:0] BOM          = 16'hfeff;
    localparam logic [15:0] ONE_BYTE_MAX = 16'h007f;
    localparam logic [15:0] TWO_BYTE_MAX = 16'h07ff;

    // utf-8 lead and continuation prefixes
    localparam logic [2:0] LEAD2_PFX = 3'b110;
    localparam logic [3:0] LEAD3_PFX = 4'b1110;
    localparam logic [1:0] CONT_PFX  = 2'b10;

    // queue between classifier and byte sequencer
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // configuration as seen by the classifier
    typedef struct packed {
        logic        ignore_errors;
        logic        skip_bom;
        logic [15:0] capacity;
    } t_cfg;

    // one job: up to three result words of one code unit
    typedef struct packed {
        logic [1:0]  nres;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        t_status     status;
        logic [15:0] total;
    } t_job;

endpackage

// ----- hw/rtl/ucs2_to_utf8_encoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ucs2_to_utf8_encoder
// UCS-2 to UTF-8 encoder: one 16-bit code unit in, up to three result words
// out, with surrogate, byte order mark and buffer capacity handling.
//
//   channel  direction  handshake                payload
//   in       input      i_in_valid / o_in_stall  i_code_unit
//   out      output     o_out_valid / i_out_stall o_out_byte, o_last_byte,
//                                                o_status, o_total_bytes
//   cfg      input      i_cfg_we                 i_cfg_index, i_cfg_wdata
//
// the output register sends one word per cycle while i_out_stall is low;
// a unit without result words is handled by the classifier alone.
// each unit is written as a job into the queue, and its first word is then
// loaded from the queue head into the output register.
// a two-entry job queue lets the input run ahead while the output stalls.
// synchronous active-low reset clears the queue, counters and configuration.
// ----------------------------------------------------------------------------
module ucs2_to_utf8_encoder
    import u2u_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [15:0] i_code_unit,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte,
    output logic [1:0]  o_status,
    output logic [15:0] o_total_bytes
);

    t_cfg r_cfg;
    logic w_push, w_pop, w_full, w_empty;
    t_job w_job, w_head;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ignore_errors <= 1'b0;
            r_cfg.skip_bom      <= 1'b0;
            r_cfg.capacity      <= CAPACITY_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_IGNORE_ERRORS:   r_cfg.ignore_errors <= i_cfg_wdata[0];
                CFG_SKIP_BOM:        r_cfg.skip_bom      <= i_cfg_wdata[0];
                CFG_BUFFER_CAPACITY: r_cfg.capacity      <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_in_stall = w_full;

    // classifier
    u2u_front #(
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_in_valid),
        .i_code_unit (i_code_unit),
        .i_accept    (!w_full),
        .o_push      (w_push),
        .o_job       (w_job)
    );

    // job queue
    u2u_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_job   (w_job),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    // byte sequencer
    u2u_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_empty       (w_empty),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_out_byte    (o_out_byte),
        .o_last_byte   (o_last_byte),
        .o_status      (o_status),
        .o_total_bytes (o_total_bytes)
    );

endmodule

// ----- hw/rtl/u2u_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u_front
// Accepts code units, classifies them, keeps the string byte count and the
// abort flag, and queues one job for every unit that produces results.
// ----------------------------------------------------------------------------
module u2u_front
    import u2u_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_in_valid,
    input  logic [15:0] i_code_unit,
    input  logic        i_accept,
    output logic        o_push,
    output t_job        o_job
);

    localparam int SW = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

    logic [COUNT_BITS-1:0] r_count, n_count;
    logic                  r_aborted, n_aborted;

    logic [SW-1:0] w_cnt, w_cnt_inc, w_sum, w_cap, w_max;
    logic [1:0]    w_n;
    logic [7:0]    w_b0, w_b1, w_b2;
    logic          w_surr, w_over;

    // encoding of the unit
    always_comb begin
        w_n  = 2'd3;
        w_b0 = {LEAD3_PFX, i_code_unit[15:12]};
        w_b1 = {CONT_PFX, i_code_unit[11:6]};
        w_b2 = {CONT_PFX, i_code_unit[5:0]};
        if (i_code_unit <= ONE_BYTE_MAX) begin
            w_n  = 2'd1;
            w_b0 = i_code_unit[7:0];
        end else if (i_code_unit <= TWO_BYTE_MAX) begin
            w_n  = 2'd2;
            w_b0 = {LEAD2_PFX, i_code_unit[10:6]};
            w_b1 = {CONT_PFX, i_code_unit[5:0]};
        end
    end

    // room checks
    assign w_cnt     = SW'(r_count);
    assign w_cnt_inc = w_cnt + SW'(1);
    assign w_sum     = w_cnt + SW'(w_n);
    assign w_cap     = SW'(i_cfg.capacity);
    assign w_max     = SW'({COUNT_BITS{1'b1}});
    assign w_over    = (w_sum > w_cap) || (w_sum > w_max);
    assign w_surr    = (i_code_unit >= SURR_LO) && (i_code_unit <= SURR_HI);

    // classification, job build and next state
    always_comb begin
        n_count      = r_count;
        n_aborted    = r_aborted;
        o_push       = 1'b0;
        o_job.nres   = 2'd1;
        o_job.b0     = 8'h00;
        o_job.b1     = w_b1;
        o_job.b2     = w_b2;
        o_job.status = ST_BYTE;
        o_job.total  = 16'h0000;
        if (i_in_valid && i_accept) begin
            priority if (i_code_unit == 16'h0000) begin
                n_count   = '0;
                n_aborted = 1'b0;
                if (!r_aborted) begin
                    o_push = 1'b1;
                    if (w_cnt_inc > w_cap) begin
                        o_job.status = ST_NOSPACE;
                    end else begin
                        o_job.status = ST_TERM;
                        o_job.total  = w_cnt[15:0];
                    end
                end
            end else if (r_aborted) begin
                // string already aborted: drop
            end else if (w_surr) begin
                if (!i_cfg.ignore_errors) begin
                    n_aborted    = 1'b1;
                    o_push       = 1'b1;
                    o_job.status = ST_SURR;
                end
            end else if ((i_code_unit == BOM) && i_cfg.skip_bom) begin
                // byte order mark dropped
            end else if (w_over) begin
                n_aborted    = 1'b1;
                o_push       = 1'b1;
                o_job.status = ST_NOSPACE;
            end else begin
                n_count     = w_sum[COUNT_BITS-1:0];
                o_push      = 1'b1;
                o_job.nres  = w_n;
                o_job.b0    = w_b0;
                o_job.total = w_cnt_inc[15:0];
            end
        end
    end

    // string state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_aborted <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_aborted <= n_aborted;
        end
    end

endmodule

// ----- hw/rtl/u2u_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u_queue
// Short job queue between the classifier and the byte sequencer.
// ----------------------------------------------------------------------------
module u2u_queue
    import u2u_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_head,
    output logic o_full,
    output logic o_empty
);

    t_job              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_fill;

    function automatic logic [QPTR_W-1:0] f_next(input logic [QPTR_W-1:0] ptr);
        logic [QPTR_W-1:0] nxt;
        nxt = (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
        return nxt;
    endfunction

    assign o_full  = (r_fill == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_head  = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= f_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= f_next(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + QCNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_fill <= r_fill - QCNT_W'(1);
            end
        end
    end

endmodule

// ----- hw/rtl/u2u_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u2u_back
// Byte sequencer: drains queued jobs one result word per cycle into the
// output register while the output is not stalled.
// ----------------------------------------------------------------------------
module u2u_back
    import u2u_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_job        i_head,
    input  logic        i_empty,
    output logic        o_pop,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_last_byte,
    output logic [1:0]  o_status,
    output logic [15:0] o_total_bytes
);

    t_job        r_job;
    logic [1:0]  r_idx;
    logic        r_busy;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    t_status     r_out_status;
    logic [15:0] r_out_total;

    logic        w_load;
    t_job        w_src;
    logic [1:0]  w_idx;
    logic        w_last;
    logic [7:0]  w_byte;

    // output slot free when empty or being taken
    assign w_load = !r_out_valid || !i_out_stall;
    assign o_pop  = w_load && !r_busy && !i_empty;

    // source of the next word: job in progress or queue head
    always_comb begin
        w_src  = r_busy ? r_job : i_head;
        w_idx  = r_busy ? r_idx : 2'd0;
        w_last = (w_idx == (w_src.nres - 2'd1));
        unique case (w_idx)
            2'd0:    w_byte = w_src.b0;
            2'd1:    w_byte = w_src.b1;
            default: w_byte = w_src.b2;
        endcase
    end

    // job progress
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (w_load && (r_busy || !i_empty)) begin
            r_busy <= !w_last;
            r_idx  <= w_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= r_busy || !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && (r_busy || !i_empty)) begin
            r_out_byte   <= w_byte;
            r_out_last   <= w_last;
            r_out_status <= w_src.status;
            r_out_total  <= w_src.total + 16'(w_idx);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_out_byte    = r_out_byte;
    assign o_last_byte   = r_out_last;
    assign o_status      = r_out_status;
    assign o_total_bytes = r_out_total;

`ifndef SYNTHESIS
    // a word that is not the last of its unit leaves a job in progress
    a_nonlast_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_last |-> r_busy)
        else $error("non-last word without job in progress");

    // terminator and error words stand alone
    a_single_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status != ST_BYTE) |-> r_out_last)
        else $error("terminator or error word not marked last");

    // job in progress points past its first word and inside its length
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_idx != 2'd0) && (r_idx < r_job.nres))
        else $error("sequencer index out of range");

    // no queue pop while a job is still being drained
    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !r_busy && !i_empty)
        else $error("pop while busy or queue empty");
`endif

endmodule
